// File: src/euler_face_half_step_flux_top_macros.svh
// Assertion macros for the face half-step flux block
`ifndef EULER_FACE_HALF_STEP_FLUX_TOP_MACROS_SVH
`define EULER_FACE_HALF_STEP_FLUX_TOP_MACROS_SVH

// same-cycle implication, reset masks the check
`define EFH_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define EFH_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/efh_pkg.sv
// Shared types, constants and microprogram for the face half-step flux block
package efh_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int NUM_W     = DW + FRAC_BITS;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int RF_DEPTH  = 32;
    localparam int NSTEPS    = 37;

    localparam logic [30:0] TIME_STEP_RST  = 31'd655;
    localparam logic [30:0] HEAT_RATIO_RST = 31'd91750;

    localparam logic CFG_TIME_STEP  = 1'b0;
    localparam logic CFG_HEAT_RATIO = 1'b1;

    typedef logic [4:0] rid_t;
    typedef logic [5:0] step_t;

    // register file slots
    localparam rid_t R_W0  = 5'd0;
    localparam rid_t R_W1  = 5'd1;
    localparam rid_t R_W2  = 5'd2;
    localparam rid_t R_W3  = 5'd3;
    localparam rid_t R_RHO = 5'd4;
    localparam rid_t R_U   = 5'd5;
    localparam rid_t R_V   = 5'd6;
    localparam rid_t R_E   = 5'd7;
    localparam rid_t R_Q   = 5'd8;
    localparam rid_t R_KE  = 5'd9;
    localparam rid_t R_P   = 5'd10;
    localparam rid_t R_EP  = 5'd11;
    localparam rid_t R_FX0 = 5'd12;
    localparam rid_t R_FX1 = 5'd13;
    localparam rid_t R_FX2 = 5'd14;
    localparam rid_t R_FX3 = 5'd15;
    localparam rid_t R_GY0 = 5'd16;
    localparam rid_t R_GY1 = 5'd17;
    localparam rid_t R_GY2 = 5'd18;
    localparam rid_t R_GY3 = 5'd19;
    localparam rid_t R_FL0 = 5'd20;
    // operand sources outside the register file
    localparam rid_t S_JAC = 5'd28;
    localparam rid_t S_M0  = 5'd29;
    localparam rid_t S_M1  = 5'd30;
    localparam rid_t S_GM1 = 5'd31;

    localparam step_t STEP_FLUX = 6'd21;
    localparam step_t STEP_LAST = 6'(NSTEPS - 1);

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_MULH,
        OP_DIV
    } alu_op_t;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_RND,
        ALU_DIV,
        ALU_FIN
    } alu_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_IN_MUL1,
        ST_IN_WAIT1,
        ST_IN_MUL2,
        ST_IN_WAIT2,
        ST_IN_WB,
        ST_CHK_RD,
        ST_CHK,
        ST_RD,
        ST_EX,
        ST_WAIT,
        ST_OUT_RD,
        ST_OUT_LD,
        ST_OUT
    } seq_state_t;

    typedef struct packed {
        alu_op_t op;
        rid_t    dst;
        rid_t    a;
        rid_t    b;
    } instr_t;

    typedef struct packed {
        logic               start;
        alu_op_t            op;
        logic signed [31:0] a;
        logic signed [31:0] b;
    } alu_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] res;
        logic signed [63:0] wide;
    } alu_rsp_t;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // compute microprogram: primitive quantities, then fluxes, then rotation
    function automatic instr_t prog(input step_t step);
        instr_t i;
        step_t  off;
        rid_t   k;
        off = step - STEP_FLUX;
        k   = rid_t'(off[3:2]);
        i   = '{op: OP_ADD, dst: R_Q, a: R_Q, b: R_Q};
        if (step < STEP_FLUX) begin
            case (step)
                6'd0:    i = '{op: OP_DIV,  dst: R_RHO, a: R_W0,  b: S_JAC};
                6'd1:    i = '{op: OP_DIV,  dst: R_U,   a: R_W1,  b: R_W0};
                6'd2:    i = '{op: OP_DIV,  dst: R_V,   a: R_W2,  b: R_W0};
                6'd3:    i = '{op: OP_DIV,  dst: R_E,   a: R_W3,  b: S_JAC};
                6'd4:    i = '{op: OP_MUL,  dst: R_Q,   a: R_U,   b: R_U};
                6'd5:    i = '{op: OP_MUL,  dst: R_KE,  a: R_V,   b: R_V};
                6'd6:    i = '{op: OP_ADD,  dst: R_Q,   a: R_Q,   b: R_KE};
                6'd7:    i = '{op: OP_MULH, dst: R_KE,  a: R_RHO, b: R_Q};
                6'd8:    i = '{op: OP_SUB,  dst: R_P,   a: R_E,   b: R_KE};
                6'd9:    i = '{op: OP_MUL,  dst: R_P,   a: S_GM1, b: R_P};
                6'd10:   i = '{op: OP_ADD,  dst: R_EP,  a: R_E,   b: R_P};
                6'd11:   i = '{op: OP_MUL,  dst: R_FX0, a: R_RHO, b: R_U};
                6'd12:   i = '{op: OP_MUL,  dst: R_FX1, a: R_FX0, b: R_U};
                6'd13:   i = '{op: OP_ADD,  dst: R_FX1, a: R_FX1, b: R_P};
                6'd14:   i = '{op: OP_MUL,  dst: R_FX2, a: R_FX0, b: R_V};
                6'd15:   i = '{op: OP_MUL,  dst: R_FX3, a: R_EP,  b: R_U};
                6'd16:   i = '{op: OP_MUL,  dst: R_GY0, a: R_RHO, b: R_V};
                6'd17:   i = '{op: OP_MUL,  dst: R_GY1, a: R_GY0, b: R_U};
                6'd18:   i = '{op: OP_MUL,  dst: R_GY2, a: R_GY0, b: R_V};
                6'd19:   i = '{op: OP_ADD,  dst: R_GY2, a: R_GY2, b: R_P};
                6'd20:   i = '{op: OP_MUL,  dst: R_GY3, a: R_EP,  b: R_V};
                default: i = '{op: OP_ADD,  dst: R_Q,   a: R_Q,   b: R_Q};
            endcase
        end else begin
            // four steps per component: m0*F, m1*G, sum, times J
            case (off[1:0])
                2'd0:    i = '{op: OP_MUL, dst: R_FL0 + k, a: S_M0,      b: R_FX0 + k};
                2'd1:    i = '{op: OP_MUL, dst: R_GY0 + k, a: S_M1,      b: R_GY0 + k};
                2'd2:    i = '{op: OP_ADD, dst: R_FL0 + k, a: R_FL0 + k, b: R_GY0 + k};
                default: i = '{op: OP_MUL, dst: R_FL0 + k, a: R_FL0 + k, b: S_JAC};
            endcase
        end
        return i;
    endfunction

endpackage

// File: src/efh_alu.sv
// Shared arithmetic unit: saturating add/sub, rounded multiply, radix-2 divider
module efh_alu
    import efh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    alu_state_t         state_reg, state_next;
    logic               done_reg, done_next;
    logic signed [31:0] res_reg, res_next;
    logic signed [63:0] wide_reg, wide_next;
    logic signed [63:0] prod_reg, prod_next;
    logic               sh1_reg, sh1_next;
    logic               neg_reg, neg_next;
    logic [NUM_W-1:0]   num_reg, num_next;
    logic [NUM_W-1:0]   quo_reg, quo_next;
    logic [31:0]        den_reg, den_next;
    logic [31:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [31:0]        mag_a, mag_b;
    logic signed [63:0] rnd;
    logic [32:0]        rem_sh;
    logic signed [NUM_W:0] qs;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ALU_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk) begin
        res_reg  <= res_next;
        wide_reg <= wide_next;
        prod_reg <= prod_next;
        sh1_reg  <= sh1_next;
        neg_reg  <= neg_next;
        num_reg  <= num_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        wide_next  = wide_reg;
        prod_next  = prod_reg;
        sh1_next   = sh1_reg;
        neg_next   = neg_reg;
        num_next   = num_reg;
        quo_next   = quo_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        mag_a      = req.a[31] ? 32'(-req.a) : 32'(req.a);
        mag_b      = req.b[31] ? 32'(-req.b) : 32'(req.b);
        rnd        = sh1_reg
                   ? (prod_reg + (64'sd1 <<< FRAC_BITS)) >>> (FRAC_BITS + 1)
                   : (prod_reg + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        rem_sh     = {rem_reg, num_reg[NUM_W-1]};
        qs         = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

        case (state_reg)
            ALU_IDLE: begin
                if (req.start) begin
                    case (req.op)
                        OP_ADD: begin
                            res_next  = sat32(66'(req.a) + 66'(req.b));
                            done_next = 1'b1;
                        end
                        OP_SUB: begin
                            res_next  = sat32(66'(req.a) - 66'(req.b));
                            done_next = 1'b1;
                        end
                        OP_MUL, OP_MULH: begin
                            prod_next  = req.a * req.b;
                            sh1_next   = (req.op == OP_MULH);
                            state_next = ALU_RND;
                        end
                        OP_DIV: begin
                            neg_next   = req.a[31] ^ req.b[31];
                            num_next   = {mag_a, {FRAC_BITS{1'b0}}};
                            den_next   = mag_b;
                            rem_next   = '0;
                            quo_next   = '0;
                            cnt_next   = '0;
                            state_next = ALU_DIV;
                        end
                        default: begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ALU_RND: begin
                wide_next  = rnd;
                res_next   = sat32(66'(rnd));
                done_next  = 1'b1;
                state_next = ALU_IDLE;
            end
            ALU_DIV: begin
                // one quotient bit per cycle, remainder stays below divisor
                if (rem_sh >= {1'b0, den_reg}) begin
                    rem_next = 32'(rem_sh - {1'b0, den_reg});
                    quo_next = {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = rem_sh[31:0];
                    quo_next = {quo_reg[NUM_W-2:0], 1'b0};
                end
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                    state_next = ALU_FIN;
            end
            ALU_FIN: begin
                res_next   = sat32(66'(qs));
                done_next  = 1'b1;
                state_next = ALU_IDLE;
            end
            default: state_next = ALU_IDLE;
        endcase
    end

    assign rsp = '{done: done_reg, res: res_reg, wide: wide_reg};

endmodule

// File: src/efh_seq.sv
// Sequencer with register file: half-step intake, flux microprogram, result output
module efh_seq
    import efh_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [255:0]   s_tdata,
    input  logic [3:0]     s_tuser,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [63:0]    m_tdata,
    output logic [2:0]     m_tuser,
    output logic           m_tlast,
    input  logic [30:0]    time_step,
    input  logic [30:0]    heat_ratio,
    output alu_req_t       alu_req,
    input  alu_rsp_t       alu_rsp
);

    seq_state_t         state_reg, state_next;
    logic [1:0]         loaded_reg, loaded_next;
    step_t              step_reg, step_next;
    logic [1:0]         k_reg, k_next;
    logic               fault_reg, fault_next;

    logic [1:0]         comp_reg, comp_next;
    logic signed [31:0] dfx_reg, dfx_next;
    logic signed [31:0] dgy_reg, dgy_next;
    logic signed [31:0] jac_reg, jac_next;
    logic signed [31:0] m0_reg, m0_next;
    logic signed [31:0] m1_reg, m1_next;
    logic signed [65:0] acc_reg, acc_next;

    logic [1:0]         o_comp_reg, o_comp_next;
    logic [31:0]        o_half_reg, o_half_next;
    logic [31:0]        o_flux_reg, o_flux_next;
    logic               o_fault_reg, o_fault_next;
    logic               o_last_reg, o_last_next;

    logic [31:0]        rf [RF_DEPTH];
    logic [31:0]        rd_a_reg, rd_b_reg;
    rid_t               rd_a_addr, rd_b_addr, rf_waddr;
    logic               rf_we;
    logic [31:0]        rf_wdata;

    instr_t             inst;
    logic signed [31:0] opa, opb, gm1, dt;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg  <= ST_IDLE;
            loaded_reg <= 2'd0;
            step_reg   <= '0;
            k_reg      <= 2'd0;
            fault_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            loaded_reg <= loaded_next;
            step_reg   <= step_next;
            k_reg      <= k_next;
            fault_reg  <= fault_next;
        end
    end

    always_ff @(posedge clk) begin
        comp_reg    <= comp_next;
        dfx_reg     <= dfx_next;
        dgy_reg     <= dgy_next;
        jac_reg     <= jac_next;
        m0_reg      <= m0_next;
        m1_reg      <= m1_next;
        acc_reg     <= acc_next;
        o_comp_reg  <= o_comp_next;
        o_half_reg  <= o_half_next;
        o_flux_reg  <= o_flux_next;
        o_fault_reg <= o_fault_next;
        o_last_reg  <= o_last_next;
    end

    // register file: one write, two registered reads
    always_ff @(posedge clk) begin
        if (rf_we)
            rf[rf_waddr] <= rf_wdata;
        rd_a_reg <= rf[rd_a_addr];
        rd_b_reg <= rf[rd_b_addr];
    end

    assign inst = prog(step_reg);
    assign dt   = $signed({1'b0, time_step});
    assign gm1  = sat32($signed({35'd0, heat_ratio}) - (66'sd1 <<< FRAC_BITS));

    always_comb begin
        case (inst.a)
            S_JAC:   opa = jac_reg;
            S_M0:    opa = m0_reg;
            S_M1:    opa = m1_reg;
            S_GM1:   opa = gm1;
            default: opa = rd_a_reg;
        endcase
        case (inst.b)
            S_JAC:   opb = jac_reg;
            S_M0:    opb = m0_reg;
            S_M1:    opb = m1_reg;
            S_GM1:   opb = gm1;
            default: opb = rd_b_reg;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        loaded_next  = loaded_reg;
        step_next    = step_reg;
        k_next       = k_reg;
        fault_next   = fault_reg;
        comp_next    = comp_reg;
        dfx_next     = dfx_reg;
        dgy_next     = dgy_reg;
        jac_next     = jac_reg;
        m0_next      = m0_reg;
        m1_next      = m1_reg;
        acc_next     = acc_reg;
        o_comp_next  = o_comp_reg;
        o_half_next  = o_half_reg;
        o_flux_next  = o_flux_reg;
        o_fault_next = o_fault_reg;
        o_last_next  = o_last_reg;
        rf_we        = 1'b0;
        rf_waddr     = R_W0;
        rf_wdata     = '0;
        rd_a_addr    = R_W0;
        rd_b_addr    = R_W0;
        alu_req      = '{start: 1'b0, op: OP_ADD, a: '0, b: '0};
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    comp_next  = s_tuser[3:2];
                    acc_next   = 66'($signed(s_tdata[31:0]));
                    dfx_next   = sat32(66'($signed(s_tdata[63:32]))
                                     - 66'($signed(s_tdata[95:64])));
                    dgy_next   = sat32(66'($signed(s_tdata[127:96]))
                                     - 66'($signed(s_tdata[159:128])));
                    jac_next   = s_tdata[191:160];
                    m0_next    = s_tdata[223:192];
                    m1_next    = s_tdata[255:224];
                    state_next = ST_IN_MUL1;
                end
            end
            ST_IN_MUL1: begin
                alu_req    = '{start: 1'b1, op: OP_MULH, a: dt, b: dfx_reg};
                state_next = ST_IN_WAIT1;
            end
            ST_IN_WAIT1: begin
                if (alu_rsp.done) begin
                    acc_next   = acc_reg + 66'(alu_rsp.wide);
                    state_next = ST_IN_MUL2;
                end
            end
            ST_IN_MUL2: begin
                alu_req    = '{start: 1'b1, op: OP_MULH, a: dt, b: dgy_reg};
                state_next = ST_IN_WAIT2;
            end
            ST_IN_WAIT2: begin
                if (alu_rsp.done) begin
                    acc_next   = acc_reg + 66'(alu_rsp.wide);
                    state_next = ST_IN_WB;
                end
            end
            ST_IN_WB: begin
                rf_we    = 1'b1;
                rf_waddr = R_W0 + rid_t'(comp_reg);
                rf_wdata = sat32(acc_reg);
                if (comp_reg != 2'd3) begin
                    if (loaded_reg != 2'd3)
                        loaded_next = loaded_reg + 2'd1;
                    state_next = ST_IDLE;
                end else begin
                    loaded_next = 2'd0;
                    state_next  = ST_CHK_RD;
                end
            end
            ST_CHK_RD: begin
                rd_a_addr  = R_W0;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                fault_next = (jac_reg == 32'sd0) || (rd_a_reg == 32'd0);
                k_next     = 2'd0;
                step_next  = '0;
                if ((jac_reg == 32'sd0) || (rd_a_reg == 32'd0))
                    state_next = ST_OUT_RD;
                else
                    state_next = ST_RD;
            end
            ST_RD: begin
                rd_a_addr  = inst.a;
                rd_b_addr  = inst.b;
                state_next = ST_EX;
            end
            ST_EX: begin
                alu_req    = '{start: 1'b1, op: inst.op, a: opa, b: opb};
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (alu_rsp.done) begin
                    rf_we    = 1'b1;
                    rf_waddr = inst.dst;
                    rf_wdata = alu_rsp.res;
                    if (step_reg == STEP_LAST) begin
                        k_next     = 2'd0;
                        state_next = ST_OUT_RD;
                    end else begin
                        step_next  = step_reg + 6'd1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_OUT_RD: begin
                rd_a_addr  = R_W0 + rid_t'(k_reg);
                rd_b_addr  = R_FL0 + rid_t'(k_reg);
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                o_comp_next  = k_reg;
                o_half_next  = rd_a_reg;
                o_flux_next  = fault_reg ? 32'd0 : rd_b_reg;
                o_fault_next = fault_reg;
                o_last_next  = (k_reg == 2'd3);
                state_next   = ST_OUT;
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    if (k_reg == 2'd3) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 2'd1;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tdata = {o_flux_reg, o_half_reg};
    assign m_tuser = {o_fault_reg, o_comp_reg};
    assign m_tlast = o_last_reg;

endmodule

// File: src/euler_face_half_step_flux_top.sv
// Top level of the face half-step flux block: config registers, sequencer, shared unit
//
// Channel   Dir  Width                Contents
// s_*       in   tdata 256, tuser 4   one conserved component with its face fluxes
// m_*       out  tdata 64, tuser 3    half-step value and rotated face flux
// cfg_*     in   addr 1, data 31      time_step (0), heat_ratio (1)
//
// Components 0..2 each run two rounded multiplies on the shared unit. Component 3
// adds a check and the flux program: 4 divides (one quotient bit a cycle over 48
// bits) plus 33 add/multiply steps, then 4 results, each held by output stalls.
// Reset (rst_n, async low) clears control and restores the config defaults; the
// register file holding the half-step values is not cleared.
// No item is taken from s_* while a result waits on m_*; m_* holds under backpressure.
`include "euler_face_half_step_flux_top_macros.svh"
module euler_face_half_step_flux_top
    import efh_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cons_value, flux_left, flux_right, flux_bottom, flux_top, jacobian,
    // metric_a, metric_b (32 bits each, lowest first)
    input  logic [255:0] s_tdata,
    // func [1:0], component [3:2]
    input  logic [3:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // half_state [31:0], face_flux [63:32]
    output logic [63:0]  m_tdata,
    // out_component [1:0], divide_fault [2]
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [30:0]  cfg_wdata
);

    logic [30:0] time_step_reg, time_step_next;
    logic [30:0] heat_ratio_reg, heat_ratio_next;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            time_step_reg  <= TIME_STEP_RST;
            heat_ratio_reg <= HEAT_RATIO_RST;
        end else begin
            time_step_reg  <= time_step_next;
            heat_ratio_reg <= heat_ratio_next;
        end
    end

    always_comb begin
        time_step_next  = time_step_reg;
        heat_ratio_next = heat_ratio_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_TIME_STEP:  time_step_next  = cfg_wdata;
                CFG_HEAT_RATIO: heat_ratio_next = cfg_wdata;
                default:        time_step_next  = time_step_reg;
            endcase
        end
    end

    efh_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .time_step  (time_step_reg),
        .heat_ratio (heat_ratio_reg),
        .alu_req    (alu_req),
        .alu_rsp    (alu_rsp)
    );

    efh_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    // intake and output never overlap
    `EFH_ASSERT_IMP(a_no_overlap, 1'b1, !(s_tready && m_tvalid), "ready while result pending")
    // an accepted item is never answered in the next cycle
    `EFH_ASSERT_NXT(a_no_early_out, s_tvalid && s_tready, !m_tvalid, "result too early")
    // last marks component 3 only
    `EFH_ASSERT_IMP(a_last_comp, m_tvalid, m_tlast == (m_tuser[1:0] == 2'd3), "bad last")
    // faulted results carry zero flux
    `EFH_ASSERT_IMP(a_fault_zero, m_tvalid && m_tuser[2], m_tdata[63:32] == 32'd0,
                    "fault with nonzero flux")

endmodule
